[hdl/vls_pkg.sv]
// shared types and constants of the vorticity leapfrog stencil
// no dependencies; every other file of the block imports it
package vls_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 48;
    localparam int COEF_FRAC = 48;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 12;
    localparam int GCOL_W    = 8;
    localparam int MAX_COLS  = 128;
    localparam int SLOT_W    = 2;
    localparam int ADDR_W    = SLOT_W + COL_W;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CHUNK_W   = 16;
    localparam int NCHUNK    = 5;
    localparam int JS_W      = CHUNK_W * NCHUNK;
    localparam int CPROD_W   = CHUNK_W + 1 + COEF_W;
    localparam int ACC_W     = 128;
    localparam int NTERMS    = 10;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] stream_value;
        logic signed [DATA_W-1:0] vort_now;
        logic signed [DATA_W-1:0] vort_prev;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_vort;
        logic [COL_W-1:0]         out_col;
        logic [ROW_W-1:0]         out_row;
        logic                     field_done;
    } t_result;

    typedef struct packed {
        logic [GCOL_W-1:0] cols;
        logic [ROW_W-1:0]  rows;
    } t_cfg;

    typedef struct packed {
        logic signed [COEF_W-1:0] jac;
        logic signed [COEF_W-1:0] beta;
    } t_coef;

    // one queued job: an optional line buffer write and an optional result
    typedef struct packed {
        logic                     wr;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] psi;
        logic signed [DATA_W-1:0] vnow;
        logic signed [DATA_W-1:0] vprev;
        logic                     emit;
        logic                     pass;
        logic                     done;
        logic [COL_W-1:0]         x;
        logic [COL_W-1:0]         xm;
        logic [COL_W-1:0]         xp;
        logic [SLOT_W-1:0]        ys;
        logic [ROW_W-1:0]         row;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_MAC,
        S_MUL,
        S_RND,
        S_FIN
    } t_back_state;

endpackage

[hdl/vls_front.sv]
// front end: raster counters, classifies points and flushes into jobs
// depends on vls_pkg
module vls_front
    import vls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_push,
    output logic  o_full,
    input  t_cfg  i_cfg,
    input  logic  i_restart,
    output t_cmd  o_cmd,
    output logic  o_q_push,
    input  logic  i_q_full
);

    logic [COL_W-1:0] r_in_col, r_em_col;
    logic [ROW_W-1:0] r_in_row, r_em_row;

    logic [GCOL_W-1:0] c_eff, c_m1;
    logic [ROW_W-1:0]  r_eff, r_m1;
    logic              acc, is_data, pt_ok, fl_ok;

    always_comb begin
        if (i_cfg.cols < GCOL_W'(3)) begin
            c_eff = GCOL_W'(3);
        end else if (i_cfg.cols > GCOL_W'(MAX_COLS)) begin
            c_eff = GCOL_W'(MAX_COLS);
        end else begin
            c_eff = i_cfg.cols;
        end
        r_eff = (i_cfg.rows < ROW_W'(3)) ? ROW_W'(3) : i_cfg.rows;
    end

    assign c_m1    = c_eff - GCOL_W'(1);
    assign r_m1    = r_eff - ROW_W'(1);
    assign o_full  = i_q_full;
    assign acc     = i_push && !i_q_full;
    assign is_data = !i_item.func;
    assign pt_ok   = (r_in_row < r_eff) && ({1'b0, r_in_col} < c_eff);
    assign fl_ok   = (r_in_row >= r_eff) && (r_em_row < r_eff) && ({1'b0, r_em_col} < c_eff);

    always_comb begin
        o_cmd.wr      = is_data && pt_ok;
        o_cmd.wr_addr = {r_in_row[SLOT_W-1:0], r_in_col};
        o_cmd.psi     = i_item.stream_value;
        o_cmd.vnow    = i_item.vort_now;
        o_cmd.vprev   = i_item.vort_prev;
        o_cmd.emit    = is_data ? (pt_ok && (r_in_row >= ROW_W'(2))) : fl_ok;
        o_cmd.pass    = (r_em_row == '0) || (r_em_row >= r_m1);
        o_cmd.done    = !is_data && (r_em_row == r_m1) && ({1'b0, r_em_col} == c_m1);
        o_cmd.x       = r_em_col;
        o_cmd.xm      = (r_em_col == '0) ? c_m1[COL_W-1:0] : r_em_col - COL_W'(1);
        o_cmd.xp      = ({1'b0, r_em_col} == c_m1) ? '0 : r_em_col + COL_W'(1);
        o_cmd.ys      = r_em_row[SLOT_W-1:0];
        o_cmd.row     = r_em_row;
    end

    assign o_q_push = acc && (o_cmd.wr || o_cmd.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_em_col <= '0;
            r_em_row <= '0;
        end else if (acc) begin
            if (o_cmd.wr) begin
                if ({1'b0, r_in_col} == c_m1) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (o_cmd.emit) begin
                if (o_cmd.done) begin
                    r_in_col <= '0;
                    r_in_row <= '0;
                    r_em_col <= '0;
                    r_em_row <= '0;
                end else if ({1'b0, r_em_col} == c_m1) begin
                    r_em_col <= '0;
                    r_em_row <= r_em_row + ROW_W'(1);
                end else begin
                    r_em_col <= r_em_col + COL_W'(1);
                end
            end
        end
    end

endmodule

[hdl/vls_queue.sv]
// job queue between front and back end
// depends on vls_pkg
module vls_queue
    import vls_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[hdl/vls_back.sv]
// back end: line buffers, jacobian multiply-accumulate, scaling and saturation
// depends on vls_pkg
module vls_back
    import vls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  t_coef   i_coef,
    output t_result o_result,
    output logic    o_empty,
    input  logic    i_pop
);

    logic signed [DATA_W-1:0] psi_mem  [4*MAX_COLS];
    logic signed [DATA_W-1:0] vort_mem [4*MAX_COLS];
    logic signed [DATA_W-1:0] prev_mem [4*MAX_COLS];

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    logic [1:0] r_dy, r_dx, r_rd_dy, r_rd_dx;
    logic       r_rd_vld;
    logic signed [DATA_W-1:0] r_rd_psi, r_rd_vort, r_rd_prev;
    logic signed [DATA_W-1:0] r_a [3][3];
    logic signed [DATA_W-1:0] r_b [3][3];
    logic signed [DATA_W-1:0] r_prev;

    logic [3:0]                r_m, r_j;
    logic                      r_pv, r_pv2, r_sub;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CPROD_W-1:0] r_prod2;
    logic [2:0]                r_sh;
    logic signed [JS_W-1:0]    r_js;
    logic signed [ACC_W-1:0]   r_t;

    logic    r_out_vld;
    t_result r_out;

    logic              wr_en, rd_en, fin_load;
    logic [ADDR_W-1:0] rd_addr, prev_addr;
    logic [SLOT_W-1:0] rd_slot;
    logic [COL_W-1:0]  rd_col;

    function automatic logic signed [DIFF_W-1:0] sx(input logic signed [DATA_W-1:0] a);
        return {a[DATA_W-1], a};
    endfunction

    function automatic logic signed [DIFF_W-1:0] df(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
        return sx(a) - sx(b);
    endfunction

    // state register and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        fin_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_cmd.emit) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_dy == 2'd2 && r_dx == 2'd2) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = r_cmd.pass ? S_FIN : S_MAC;
            end
            S_MAC: begin
                if (r_m == 4'(NTERMS)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_j == 4'(2 * NCHUNK)) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || i_pop) begin
                    fin_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // line buffer ports
    assign wr_en     = o_q_pop && i_cmd.wr;
    assign rd_en     = (r_state == S_READ);
    assign rd_slot   = r_cmd.ys + SLOT_W'(r_dy) + SLOT_W'(3);
    assign rd_col    = (r_dx == 2'd0) ? r_cmd.xm : ((r_dx == 2'd1) ? r_cmd.x : r_cmd.xp);
    assign rd_addr   = {rd_slot, rd_col};
    assign prev_addr = {r_cmd.ys, r_cmd.x};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            psi_mem[i_cmd.wr_addr]  <= i_cmd.psi;
            vort_mem[i_cmd.wr_addr] <= i_cmd.vnow;
            prev_mem[i_cmd.wr_addr] <= i_cmd.vprev;
        end
        if (rd_en) begin
            r_rd_psi  <= psi_mem[rd_addr];
            r_rd_vort <= vort_mem[rd_addr];
            r_rd_prev <= prev_mem[prev_addr];
        end
    end

    // jacobian term selection
    logic signed [DIFF_W-1:0] op_x, op_y;
    logic                     op_sub;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        op_x   = '0;
        op_y   = '0;
        op_sub = 1'b0;
        case (r_m)
            4'd0: begin op_x = df(r_a[1][2], r_a[1][0]); op_y = df(r_b[2][1], r_b[0][1]); end
            4'd1: begin
                op_x = df(r_b[1][2], r_b[1][0]); op_y = df(r_a[2][1], r_a[0][1]); op_sub = 1'b1;
            end
            4'd2: begin op_x = sx(r_a[1][2]); op_y = df(r_b[2][2], r_b[0][2]); end
            4'd3: begin op_x = sx(r_a[1][0]); op_y = df(r_b[2][0], r_b[0][0]); op_sub = 1'b1; end
            4'd4: begin op_x = sx(r_a[2][1]); op_y = df(r_b[2][2], r_b[2][0]); op_sub = 1'b1; end
            4'd5: begin op_x = sx(r_a[0][1]); op_y = df(r_b[0][2], r_b[0][0]); end
            4'd6: begin op_x = sx(r_b[2][1]); op_y = df(r_a[2][2], r_a[2][0]); end
            4'd7: begin op_x = sx(r_b[0][1]); op_y = df(r_a[0][2], r_a[0][0]); op_sub = 1'b1; end
            4'd8: begin op_x = sx(r_b[1][2]); op_y = df(r_a[2][2], r_a[0][2]); op_sub = 1'b1; end
            4'd9: begin op_x = sx(r_b[1][0]); op_y = df(r_a[2][0], r_a[0][0]); end
            default: begin op_x = '0; op_y = '0; op_sub = 1'b0; end
        endcase
    end

    assign mul_p = op_x * op_y;

    // coefficient multiply: 16-bit slices of the sum and of the psi difference against a full coefficient
    logic signed [JS_W-1:0]    beta_src;
    logic [JS_W-1:0]           slice_src;
    logic [2:0]                ci;
    logic [CHUNK_W-1:0]        slice;
    logic signed [CHUNK_W:0]   slice_s;
    logic signed [COEF_W-1:0]  coef_sel;
    logic signed [CPROD_W-1:0] cmul_p;

    assign beta_src  = JS_W'(df(r_a[1][2], r_a[1][0]));
    assign slice_src = (r_j < 4'(NCHUNK)) ? r_js : beta_src;
    assign ci        = (r_j < 4'(NCHUNK)) ? r_j[2:0] : 3'(r_j - 4'(NCHUNK));
    assign slice     = slice_src[ci*CHUNK_W +: CHUNK_W];
    assign slice_s   = (ci == 3'(NCHUNK - 1)) ? {slice[CHUNK_W-1], slice} : {1'b0, slice};
    assign coef_sel  = (r_j < 4'(NCHUNK)) ? i_coef.jac : i_coef.beta;
    assign cmul_p    = slice_s * coef_sel;

    // final rounding subtract and saturation
    logic signed [JS_W-1:0]  shv;
    logic signed [JS_W:0]    dv;
    logic signed [DATA_W-1:0] sat_v;

    assign shv = r_t[ACC_W-1 -: JS_W];
    assign dv  = (JS_W+1)'(r_prev) - (JS_W+1)'(shv);

    always_comb begin
        if (dv[JS_W:DATA_W-1] == '0 || dv[JS_W:DATA_W-1] == '1) begin
            sat_v = dv[DATA_W-1:0];
        end else if (dv[JS_W]) begin
            sat_v = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_v = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_dy <= r_dy;
        r_rd_dx <= r_dx;
        if (r_rd_vld) begin
            r_a[r_rd_dy][r_rd_dx] <= r_rd_psi;
            r_b[r_rd_dy][r_rd_dx] <= r_rd_vort;
            r_prev                <= r_rd_prev;
        end
        case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    r_cmd <= i_cmd;
                    r_dy  <= '0;
                    r_dx  <= '0;
                end
            end
            S_READ: begin
                if (r_dx == 2'd2) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
            S_WAIT: begin
                r_m   <= '0;
                r_pv  <= 1'b0;
                r_js  <= '0;
                r_j   <= '0;
                r_pv2 <= 1'b0;
                r_t   <= '0;
            end
            S_MAC: begin
                if (r_m < 4'(NTERMS)) begin
                    r_prod <= mul_p;
                    r_sub  <= op_sub;
                    r_pv   <= 1'b1;
                    r_m    <= r_m + 4'd1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_js <= r_sub ? r_js - JS_W'(r_prod) : r_js + JS_W'(r_prod);
                end
            end
            S_MUL: begin
                if (r_j < 4'(2 * NCHUNK)) begin
                    r_prod2 <= cmul_p;
                    r_sh    <= ci;
                    r_pv2   <= 1'b1;
                    r_j     <= r_j + 4'd1;
                end else begin
                    r_pv2 <= 1'b0;
                end
                if (r_pv2) begin
                    r_t <= r_t + (ACC_W'(r_prod2) <<< {r_sh, 4'b0000});
                end
            end
            S_RND: begin
                r_t <= r_t + (ACC_W'(1) <<< (COEF_FRAC - 1));
            end
            default: begin
            end
        endcase
        if (fin_load) begin
            r_out.new_vort   <= r_cmd.pass ? r_b[1][1] : sat_v;
            r_out.out_col    <= r_cmd.x;
            r_out.out_row    <= r_cmd.row;
            r_out.field_done <= r_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_vld;

endmodule

[hdl/vorticity_leapfrog_stencil.sv]
// vorticity leapfrog stencil: top level, register port and block wiring
// depends on vls_pkg, vls_front, vls_queue, vls_back
//
// usage
//   input channel: push / full, one grid point or flush word per accepted push
//   result channel: empty / pop, oldest result shown while empty is low
//   register port: apb-style, 64-bit data, register i at byte address 8*i
//     0 columns_in_use, 1 rows_in_use, 2 jacobian_coef, 3 beta_coef
//   a point at row y+2 releases the result of row y; flush words drain the
//   last two rows, the final one carries field_done
//   timing: the front end takes one word per cycle into a job queue while it has
//   room; the back end takes a plain buffer write straight from the queue, a boundary
//   row result runs the nine single-port line buffer reads, and an interior result
//   adds ten jacobian products on one multiplier and ten 16-bit slices of the
//   coefficient products
//   reset: counters, queue and result register cleared, registers to defaults;
//   the line buffers hold no reset value
//   a stalled receiver stops the back end only at its result register; the
//   queue keeps taking words until it fills, then full rises
module vorticity_leapfrog_stencil
    import vls_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_item       i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_JAC  = 2'd2;
    localparam logic [1:0] REG_BETA = 2'd3;

    // configuration registers
    logic [GCOL_W-1:0]        r_cols;
    logic [ROW_W-1:0]         r_rows;
    logic signed [COEF_W-1:0] r_jac, r_beta;
    logic                     cfg_wr, restart;
    logic [1:0]               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;
    // a geometry write starts a new field
    assign restart = cfg_wr && (reg_idx == REG_COLS || reg_idx == REG_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= GCOL_W'(128);
            r_rows <= ROW_W'(64);
            r_jac  <= '0;
            r_beta <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COLS: r_cols <= pwdata[GCOL_W-1:0];
                REG_ROWS: r_rows <= pwdata[ROW_W-1:0];
                REG_JAC:  r_jac  <= pwdata[COEF_W-1:0];
                REG_BETA: r_beta <= pwdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLS: prdata = 64'(r_cols);
            REG_ROWS: prdata = 64'(r_rows);
            REG_JAC:  prdata = 64'(unsigned'(r_jac));
            REG_BETA: prdata = 64'(unsigned'(r_beta));
            default:  prdata = '0;
        endcase
    end

    t_cfg  cfg;
    t_coef coef;

    assign cfg.cols  = r_cols;
    assign cfg.rows  = r_rows;
    assign coef.jac  = r_jac;
    assign coef.beta = r_beta;

    // front end to queue to back end
    t_cmd f_cmd, q_cmd;
    logic f_push, q_full, q_pop, q_empty;

    vls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_push    (push),
        .o_full    (full),
        .i_cfg     (cfg),
        .i_restart (restart),
        .o_cmd     (f_cmd),
        .o_q_push  (f_push),
        .i_q_full  (q_full)
    );

    vls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    vls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_coef    (coef),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

[hdl/vls_checker.sv]
// port-level checks of the vorticity leapfrog stencil, bound to the top level
// depends on vls_pkg and vorticity_leapfrog_stencil
module vls_checker
    import vls_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // result register is cleared by reset
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // job queue is cleared by reset
    a_room_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

    // the last point of a field lies at least on row two
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.field_done |-> o_result.out_row >= ROW_W'(2))
        else $error("field end flagged on an early row");

endmodule

bind vorticity_leapfrog_stencil vls_checker u_vls_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the vorticity leapfrog stencil: scoreboard class with its own predictor
// depends on vls_pkg and vorticity_leapfrog_stencil
module tb;
    import vls_pkg::*;

    typedef logic signed [255:0] t_wide;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 300;

    // predictor of the stencil plus the queue of predicted words
    class vort_scoreboard;
        longint      psi_buf[4*MAX_COLS];
        longint      vort_buf[4*MAX_COLS];
        longint      prev_buf[4*MAX_COLS];
        int unsigned col_in, row_in, col_out, row_out;
        int unsigned cols_reg, rows_reg;
        logic signed [COEF_W-1:0] jac, beta;
        t_result     pending[$];
        int          errors;

        function new();
            for (int i = 0; i < 4*MAX_COLS; i++) begin
                psi_buf[i] = 0;
                vort_buf[i] = 0;
                prev_buf[i] = 0;
            end
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
            cols_reg = 128; rows_reg = 64; jac = '0; beta = '0;
            errors = 0;
        endfunction

        function int unsigned eff_cols();
            if (cols_reg < 3) return 3;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned eff_rows();
            return (rows_reg < 3) ? 3 : rows_reg;
        endfunction

        function void write_reg(int idx, logic [63:0] v);
            case (idx)
                0: cols_reg = v[7:0];
                1: rows_reg = v[11:0];
                2: jac = v[COEF_W-1:0];
                3: beta = v[COEF_W-1:0];
                default: ;
            endcase
            // geometry change restarts the field, buffers stay
            if (idx <= 1) begin
                col_in = 0; row_in = 0; col_out = 0; row_out = 0;
            end
        endfunction

        function t_wide prod(longint x, longint y);
            t_wide p, q;
            p = x;
            q = y;
            return p * q;
        endfunction

        function longint stencil(int unsigned x, int unsigned y, int unsigned c);
            longint      a[3][3];
            longint      b[3][3];
            int unsigned xs[3];
            int unsigned k;
            t_wide       js, t, jw, bw, d, one, r, hi, lo;
            xs[0] = (x == 0) ? c - 1 : x - 1;
            xs[1] = x;
            xs[2] = (x + 1 >= c) ? 0 : x + 1;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++) begin
                    k = ((y + dy + 3) & 3) * MAX_COLS + xs[dx];
                    a[dy][dx] = psi_buf[k];
                    b[dy][dx] = vort_buf[k];
                end
            // arakawa nine-point sum, weights folded into the coefficient
            js = prod(a[1][2] - a[1][0], b[2][1] - b[0][1])
               - prod(b[1][2] - b[1][0], a[2][1] - a[0][1])
               + prod(a[1][2], b[2][2] - b[0][2])
               - prod(a[1][0], b[2][0] - b[0][0])
               - prod(a[2][1], b[2][2] - b[2][0])
               + prod(a[0][1], b[0][2] - b[0][0])
               + prod(b[2][1], a[2][2] - a[2][0])
               - prod(b[0][1], a[0][2] - a[0][0])
               - prod(b[1][2], a[2][2] - a[0][2])
               + prod(b[1][0], a[2][0] - a[0][0]);
            jw = jac;
            bw = beta;
            d = a[1][2] - a[1][0];
            one = 1;
            t = js * jw + bw * d + (one <<< (COEF_FRAC - 1));
            t = t >>> COEF_FRAC;
            r = prev_buf[(y & 3) * MAX_COLS + x];
            r = r - t;
            hi = 64'sd2147483647;
            lo = -64'sd2147483648;
            if (r > hi) return 64'sd2147483647;
            if (r < lo) return -64'sd2147483648;
            return longint'(r);
        endfunction

        function void produce(int unsigned c, int unsigned r, bit done);
            t_result     res;
            longint      v;
            int unsigned x, y;
            x = col_out;
            y = row_out;
            if (y == 0 || y >= r - 1) v = vort_buf[(y & 3) * MAX_COLS + x];
            else v = stencil(x, y, c);
            res.new_vort   = v[DATA_W-1:0];
            res.out_col    = x[COL_W-1:0];
            res.out_row    = y[ROW_W-1:0];
            res.field_done = done;
            pending.push_back(res);
            col_out++;
            if (col_out >= c) begin
                col_out = 0;
                row_out++;
            end
        endfunction

        // accepted input word
        function void note_word(t_item w);
            int unsigned c, r, k;
            bit          emit, done;
            c = eff_cols();
            r = eff_rows();
            if (!w.func) begin
                if (row_in >= r || col_in >= c) return;
                k = (row_in & 3) * MAX_COLS + col_in;
                psi_buf[k]  = w.stream_value;
                vort_buf[k] = w.vort_now;
                prev_buf[k] = w.vort_prev;
                emit = row_in >= 2;
                col_in++;
                if (col_in >= c) begin
                    col_in = 0;
                    row_in++;
                end
                if (emit) produce(c, r, 1'b0);
            end else begin
                if (row_in < r || row_out >= r || col_out >= c) return;
                done = (row_out == r - 1) && (col_out == c - 1);
                produce(c, r, done);
                if (done) begin
                    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // accepted result word against the oldest prediction
        task check(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.new_vort !== want.new_vort)
                report($sformatf("new_vort %0d want %0d at (%0d,%0d)", got.new_vort,
                                 want.new_vort, want.out_col, want.out_row));
            if (got.out_col !== want.out_col)
                report($sformatf("out_col %0d want %0d", got.out_col, want.out_col));
            if (got.out_row !== want.out_row)
                report($sformatf("out_row %0d want %0d", got.out_row, want.out_row));
            if (got.field_done !== want.field_done)
                report($sformatf("field_done %0b want %0b at (%0d,%0d)", got.field_done,
                                 want.field_done, want.out_col, want.out_row));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_item       i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    vort_scoreboard board = new();
    bit          quiet = 1'b0;   // no idling in the closing part
    int          cycles = 0;
    int          rand_words = 0;
    int          pop_hold = 0;

    vorticity_leapfrog_stencil dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random pop stalls in bursts, checks on the rising edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (quiet || !i_rst_n) begin
                pop = 1'b1;
            end else if (pop_hold > 0) begin
                pop = 1'b0;
                pop_hold--;
            end else if ($urandom_range(0, 9) == 0) begin
                pop = 1'b0;
                pop_hold = $urandom_range(0, 16);
            end else begin
                pop = 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) board.check(o_result);
        end
    end

    // register write: setup cycle then access cycle
    task reg_write(int idx, logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 5'(idx * 8);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // one input word; push stays high after acceptance for back-to-back words
    task send_word(t_item w);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) begin
                @(negedge i_clk);
                push = 1'b0;
                i_item = {1'($urandom), $urandom, $urandom, $urandom};
            end
        end
        @(negedge i_clk);
        push = 1'b1;
        i_item = w;
        do @(posedge i_clk); while (full);
        board.note_word(w);
    endtask

    task push_off();
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // wait for every predicted word, then let the back end settle
    task drain();
        push_off();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function logic [31:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return $urandom_range(0, 2000) - 1000;
            5: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function logic [63:0] pick_coef();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v[47:0] = '0;
            1: v[47:0] = 48'h7fffffffffff;
            2: v[47:0] = 48'h800000000000;
            3: v[47:0] = {{16{v[31]}}, v[31:0]} >>> $urandom_range(0, 31);
            4: v[47:0] = $signed(v[47:0]) >>> $urandom_range(16, 46);
            default: ;
        endcase
        return v;
    endfunction

    function t_item data_word();
        t_item w;
        w.func = 1'b0;
        w.stream_value = pick_data();
        w.vort_now = pick_data();
        w.vort_prev = pick_data();
        return w;
    endfunction

    function t_item flush_word();
        t_item w;
        w = {1'($urandom), $urandom, $urandom, $urandom};
        w.func = 1'b1;
        return w;
    endfunction

    // full field: data in raster order, then flushes for the last two rows
    task send_field(int c, int r, bit noise);
        if (noise && $urandom_range(0, 3) == 0) begin
            send_word(flush_word());   // early flush, ignored
            rand_words++;
        end
        for (int i = 0; i < c * r; i++) begin
            send_word(data_word());
            rand_words++;
        end
        if (noise && $urandom_range(0, 3) == 0) begin
            send_word(data_word());    // data after a complete field, ignored
            rand_words++;
        end
        for (int i = 0; i < 2 * c; i++) begin
            send_word(flush_word());
            rand_words++;
        end
        if (noise && $urandom_range(0, 3) == 0) begin
            send_word(flush_word());   // flush after the field restarted, ignored
            rand_words++;
        end
    endtask

    function int clamp_cols(int v);
        return (v < 3) ? 3 : (v > MAX_COLS) ? MAX_COLS : v;
    endfunction

    initial begin
        int   c, r;
        t_item w;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: clamped 3x3 field, saturating coefficients, extreme data
        reg_write(0, 64'hffffffff_ffffff00);
        reg_write(1, 64'h0000000000000001);
        reg_write(2, 64'h00007fffffffffff);
        reg_write(3, 64'hffff800000000000);
        send_word(flush_word());
        for (int i = 0; i < 9; i++) begin
            w.func = 1'b0;
            w.stream_value = (i % 2) ? 32'h7fffffff : 32'h80000000;
            w.vort_now = (i % 3 == 0) ? 32'h80000000 : 32'h7fffffff;
            w.vort_prev = (i % 4 == 0) ? 32'h7fffffff : 32'h80000000;
            send_word(w);
        end
        send_word(data_word());
        for (int i = 0; i < 6; i++) send_word(flush_word());
        send_word(flush_word());
        drain();

        // widest rows, clamped from 255; first rows only, then abandoned
        reg_write(0, 64'h00000000000000ff);
        reg_write(1, 64'h0000000000000003);
        reg_write(2, 64'hffff800000000000);
        reg_write(3, 64'h00007fffffffffff);
        for (int i = 0; i < 2 * MAX_COLS + 3; i++) send_word(data_word());
        drain();

        // tallest field, started and then abandoned by a geometry write
        reg_write(0, 64'h0000000000000003);
        reg_write(1, 64'h0000000000000fff);
        reg_write(2, pick_coef());
        reg_write(3, pick_coef());
        for (int i = 0; i < 15; i++) send_word(data_word());
        drain();

        // random small fields
        rand_words = 0;
        while (rand_words < 80) begin
            c = $urandom_range(0, 10);
            r = $urandom_range(0, 8);
            reg_write(0, {$urandom, $urandom} & 64'hffffffff_ffffff00 | c);
            reg_write(1, {$urandom, $urandom} & 64'hffffffff_fffff000 | r);
            if ($urandom_range(0, 1)) reg_write(2, pick_coef());
            if ($urandom_range(0, 1)) reg_write(3, pick_coef());
            send_field(clamp_cols(c), (r < 3) ? 3 : r, 1'b1);
            drain();
        end

        // closing field with no idling on either side
        quiet = 1'b1;
        reg_write(0, 64'h0000000000000005);
        reg_write(1, 64'h0000000000000004);
        reg_write(2, pick_coef());
        reg_write(3, pick_coef());
        send_field(5, 4, 1'b0);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
hdl/vls_pkg.sv
hdl/vls_front.sv
hdl/vls_queue.sv
hdl/vls_back.sv
hdl/vorticity_leapfrog_stencil.sv
hdl/vls_checker.sv
sim/tb.sv
